// ===== rtl/mcpr_pkg.sv =====
`default_nettype none

package mcpr_pkg;

   // packet types taken from the fixed header's high nibble
   localparam logic [3:0] KIND_CONNECT   = 4'd1;
   localparam logic [3:0] KIND_SUBSCRIBE = 4'd8;
   localparam logic [3:0] KIND_PINGREQ   = 4'd12;

   // remaining length encoding
   localparam int          LEN_W       = 28;
   localparam logic [7:0]  LEN_CONT    = 8'd128;
   localparam logic [6:0]  LEN_GROUP   = 7'd127;
   localparam logic [7:0]  TYPE_MASK   = 8'hf0;

   // response header bytes
   localparam logic [7:0] HDR_CONNACK  = 8'h20;
   localparam logic [7:0] HDR_SUBACK   = 8'h90;
   localparam logic [7:0] HDR_PINGRESP = 8'hd0;

   // command queue between parser and emitter
   localparam int CMD_DEPTH = 4;

   typedef enum logic [1:0] {
      CMD_CONNACK,
      CMD_SUBACK,
      CMD_PINGRESP,
      CMD_ERROR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [15:0]  ident;
   } cmd_type;

   // index of the final byte of each response
   function automatic logic [2:0] cmd_last_idx(input cmd_kind_type kind);
      logic [2:0] r;
      case (kind)
         CMD_CONNACK:  r = 3'd3;
         CMD_SUBACK:   r = 3'd4;
         CMD_PINGRESP: r = 3'd1;
         CMD_ERROR:    r = 3'd0;
         default:      r = 3'd0;
      endcase
      return r;
   endfunction

   // response byte at a given position
   function automatic logic [7:0] cmd_byte(input cmd_type cmd, input logic [2:0] idx);
      logic [7:0] r;
      r = 8'h00;
      case (cmd.kind)
         CMD_CONNACK: begin
            if (idx == 3'd0) r = HDR_CONNACK;
            else if (idx == 3'd1) r = 8'h02;
         end
         CMD_SUBACK: begin
            case (idx)
               3'd0:    r = HDR_SUBACK;
               3'd1:    r = 8'h03;
               3'd2:    r = cmd.ident[15:8];
               3'd3:    r = cmd.ident[7:0];
               default: r = 8'h00;
            endcase
         end
         CMD_PINGRESP: begin
            if (idx == 3'd0) r = HDR_PINGRESP;
         end
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/mcpr_ifs.sv =====
`default_nettype none

// received byte stream
interface mcpr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

// response byte stream
interface mcpr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;
   logic       status;
   modport source (output valid, output out_byte, output out_last, output status, input ready);
   modport sink   (input valid, input out_byte, input out_last, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/mcpr_parser.sv =====
`default_nettype none

module mcpr_parser
   import mcpr_pkg::*;
#(
   parameter int MAX_LENGTH_BYTES = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    accept,
   input  wire logic [7:0] in_byte,
   output logic         push,
   output cmd_type      push_cmd
);

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_LENGTH,
      PH_BODY
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [3:0]         kind_ff, kind_in;
   logic [LEN_W-1:0]   acc_ff, acc_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic [LEN_W-1:0]   rem_ff, rem_in;
   logic [15:0]        ident_ff, ident_in;
   logic [1:0]         seen_ff, seen_in;
   logic               halted_ff, halted_in;

   logic [LEN_W-1:0]   term;
   logic [LEN_W-1:0]   acc_sum;
   logic [LEN_W-1:0]   rem_dec;
   logic [2:0]         cnt_inc;
   logic               emit;

   // length group placed by its position in the length field
   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    term = {21'd0, in_byte[6:0] & LEN_GROUP};
         2'd1:    term = {14'd0, in_byte[6:0] & LEN_GROUP, 7'd0};
         2'd2:    term = {7'd0, in_byte[6:0] & LEN_GROUP, 14'd0};
         default: term = {in_byte[6:0] & LEN_GROUP, 21'd0};
      endcase
   end

   assign acc_sum = acc_ff + term;
   assign rem_dec = rem_ff - LEN_W'(1);
   assign cnt_inc = cnt_ff + 3'd1;

   // next-state of the packet walk
   always_comb begin
      phase_in  = phase_ff;
      kind_in   = kind_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      ident_in  = ident_ff;
      seen_in   = seen_ff;
      halted_in = halted_ff;
      emit      = 1'b0;
      push      = 1'b0;
      push_cmd  = '{kind: CMD_ERROR, ident: ident_ff};

      if (accept && !halted_ff) begin
         case (phase_ff)
            PH_LENGTH: begin
               acc_in = acc_sum;
               cnt_in = cnt_inc;
               if ((in_byte & LEN_CONT) != 8'd0) begin
                  if (cnt_inc >= 3'(MAX_LENGTH_BYTES)) begin
                     halted_in = 1'b1;
                     push      = 1'b1;
                  end
               end else begin
                  rem_in = acc_sum;
                  if (acc_sum == '0) begin
                     emit     = 1'b1;
                     phase_in = PH_HEADER;
                  end else begin
                     phase_in = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               if (kind_ff == KIND_SUBSCRIBE && seen_ff < 2'd2) begin
                  if (seen_ff == 2'd0) ident_in = {in_byte, 8'd0};
                  else                 ident_in = ident_ff | {8'd0, in_byte};
                  seen_in = seen_ff + 2'd1;
               end
               rem_in = rem_dec;
               if (rem_dec == '0) begin
                  emit     = 1'b1;
                  phase_in = PH_HEADER;
               end
            end
            default: begin
               kind_in  = 4'((in_byte & TYPE_MASK) >> 4);
               acc_in   = '0;
               cnt_in   = '0;
               rem_in   = '0;
               ident_in = '0;
               seen_in  = '0;
               phase_in = PH_LENGTH;
            end
         endcase
      end

      // response command for a finished packet
      if (emit) begin
         push_cmd.ident = ident_in;
         if (kind_ff == KIND_CONNECT) begin
            push = 1'b1;
            push_cmd.kind = CMD_CONNACK;
         end else if (kind_ff == KIND_SUBSCRIBE) begin
            push = 1'b1;
            push_cmd.kind = CMD_SUBACK;
         end else if (kind_ff == KIND_PINGREQ) begin
            push = 1'b1;
            push_cmd.kind = CMD_PINGRESP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         kind_ff   <= '0;
         acc_ff    <= '0;
         cnt_ff    <= '0;
         rem_ff    <= '0;
         ident_ff  <= '0;
         seen_ff   <= '0;
         halted_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         kind_ff   <= kind_in;
         acc_ff    <= acc_in;
         cnt_ff    <= cnt_in;
         rem_ff    <= rem_in;
         ident_ff  <= ident_in;
         seen_ff   <= seen_in;
         halted_ff <= halted_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/mcpr_cmd_queue.sv =====
`default_nettype none

module mcpr_cmd_queue
   import mcpr_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  cmd_type   push_cmd,
   output logic      full,
   input  wire logic pop,
   output logic      head_valid,
   output cmd_type   head_cmd
);

   localparam int PTR_W = $clog2(CMD_DEPTH);
   localparam int CNT_W = $clog2(CMD_DEPTH + 1);

   cmd_type            slot_ff [CMD_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == CNT_W'(CMD_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = wr_ptr_ff + PTR_W'(1);
      if (pop)  rd_ptr_in = rd_ptr_ff + PTR_W'(1);
      if (push && !pop)      count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // command slots
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

`default_nettype wire

// ===== rtl/mcpr_emitter.sv =====
`default_nettype none

module mcpr_emitter
   import mcpr_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   head_valid,
   input  cmd_type     head_cmd,
   output logic        pop,
   mcpr_rsp_if.source  rsp
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       status_ff, status_in;
   logic [2:0] idx_ff, idx_in;
   logic       load;
   logic       final_word;

   assign load       = head_valid && (!valid_ff || rsp.ready);
   assign final_word = (idx_ff == cmd_last_idx(head_cmd.kind));
   assign pop        = load && final_word;

   // output register, refilled from the queue head one word per cycle unless stalled
   always_comb begin
      valid_in  = valid_ff;
      byte_in   = byte_ff;
      last_in   = last_ff;
      status_in = status_ff;
      idx_in    = idx_ff;
      if (load) begin
         valid_in  = 1'b1;
         byte_in   = cmd_byte(head_cmd, idx_ff);
         last_in   = final_word;
         status_in = (head_cmd.kind == CMD_ERROR);
         idx_in    = final_word ? 3'd0 : idx_ff + 3'd1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      last_ff   <= last_in;
      status_ff <= status_in;
   end

   assign rsp.valid    = valid_ff;
   assign rsp.out_byte = byte_ff;
   assign rsp.out_last = last_ff;
   assign rsp.status   = status_ff;

endmodule

`default_nettype wire

// ===== rtl/mqtt_control_packet_responder_unit.sv =====
`default_nettype none

// Broker-side MQTT responder. One received byte is taken per cycle on req_ch
// whenever the four-entry response command queue has room; the parser reads
// the fixed header, the remaining length and the body and queues one command
// at the end of each CONNECT, SUBSCRIBE or PINGREQ packet. The emitter turns
// the queue head into CONNACK (4 words), SUBACK (5 words, identifier MSB first)
// or PINGRESP (2 words) on rsp_ch, one word per cycle from an output register
// while rsp_ch is ready, so sustained input rate is one byte per cycle unless
// short packets arrive faster than their responses drain, when the queue fills
// and ready drops. A remaining length whose final permitted byte still has its
// continuation bit set yields one word with status 1, after which all input is
// accepted and discarded until reset. There is no start-up clearing pass.
module mqtt_control_packet_responder_unit
   import mcpr_pkg::*;
#(
   parameter int MAX_LENGTH_BYTES = 4
) (
   input  wire logic  clock,
   input  wire logic  reset,
   mcpr_req_if.sink   req_ch,
   mcpr_rsp_if.source rsp_ch
);

   logic    accept;
   logic    push;
   cmd_type push_cmd;
   logic    full;
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;

   assign req_ch.ready = !full;
   assign accept       = req_ch.valid && !full;

   // front: byte parser
   mcpr_parser #(
      .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_ch.in_byte),
      .push    (push),
      .push_cmd(push_cmd)
   );

   // response commands waiting for the emitter
   mcpr_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (full),
      .pop       (pop),
      .head_valid(head_valid),
      .head_cmd  (head_cmd)
   );

   // back: response word emitter
   mcpr_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .head_valid(head_valid),
      .head_cmd  (head_cmd),
      .pop       (pop),
      .rsp       (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== rtl/mcpr_checker.sv =====
`default_nettype none

module mcpr_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] out_byte,
   input wire logic       out_last,
   input wire logic       status
);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte)
         && $stable(out_last) && $stable(status))
      else $error("response word changed while stalled");

   // the error word is a single zero word
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status |-> out_last && out_byte == 8'd0)
      else $error("malformed error word");

   // nothing follows the error word
   a_err_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && status |=> !rsp_valid)
      else $error("response after error word");

   // reset empties the output
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   // input is taken whenever queue has room, so ready never falls without traffic
   a_ready_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(req_valid))
      else $error("ready dropped with no byte taken");

endmodule

bind mqtt_control_packet_responder_unit mcpr_checker u_mcpr_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_ch.valid),
   .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .out_byte (rsp_ch.out_byte),
   .out_last (rsp_ch.out_last),
   .status   (rsp_ch.status)
);

`default_nettype wire
